FILE: hdl/ksv_pkg.sv
// ----------------------------------------------------------------------------
// ksv_pkg: shared types and constants of the plucked string voice
// Function codes, voice modes, register indexes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ksv_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_GATE  = 2'd1;
  localparam logic [1:0] FUNC_RESET = 2'd2;

  localparam logic [1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [1:0] REG_DECAY_PLUCKED = 2'd1;
  localparam logic [1:0] REG_DECAY_RELEASE = 2'd2;
  localparam logic [1:0] REG_DECAY_RESET   = 2'd3;

  localparam logic [31:0] PHASE_STEP_RST    = 32'd0;
  localparam logic [15:0] DECAY_PLUCKED_RST = 16'd32768;
  localparam logic [15:0] DECAY_RELEASE_RST = 16'd26214;
  localparam logic [15:0] DECAY_RESET_RST   = 16'd328;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PLUCKED,
    MODE_RELEASE,
    MODE_SOFT
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_IDLE_OUT,
    ST_TREAD,
    ST_TMUL,
    ST_TWB,
    ST_FLCG,
    ST_FMUL,
    ST_FWR,
    ST_FLAST
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_FILL,
    WR_LAST,
    WR_TICK
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    mul_en;
    logic    lcg_en;
    logic    noise_mul_en;
    logic    cnt_inc;
    wr_sel_t wr_sel;
    logic    tick_commit;
    logic    out_load;
    logic    out_zero;
  } ksv_cmd_t;

  typedef struct packed {
    logic item_tick;
    logic item_fill;
    logic item_hard;
    logic mode_idle;
    logic fill_end;
    logic clear_end;
    logic out_free;
  } ksv_stat_t;

endpackage

`default_nettype wire

FILE: hdl/ksv_if.sv
// ----------------------------------------------------------------------------
// ksv_if: request and result channels of the plucked string voice
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ksv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] gate_level;
  logic        hard_reset;

  modport source (output valid, output func, output gate_level, output hard_reset,
                  input ready);
  modport sink (input valid, input func, input gate_level, input hard_reset,
                output ready);
endinterface

interface ksv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               active;

  modport source (output valid, output sample, output active, input ready);
  modport sink (input valid, input sample, input active, output ready);
endinterface

`default_nettype wire

FILE: hdl/ksv_ram.sv
// ----------------------------------------------------------------------------
// ksv_ram: generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ksv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ksv_ctrl.sv
// ----------------------------------------------------------------------------
// ksv_ctrl: sequencer of the plucked string voice
// Steps ticks, noise fills and clearing passes through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ksv_ctrl
  import ksv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ksv_stat_t stat,
  output ksv_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.item_tick) begin
            state_next = stat.mode_idle ? ST_IDLE_OUT : ST_TREAD;
          end else if (stat.item_fill) begin
            state_next = ST_FLCG;
          end else if (stat.item_hard) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_IDLE_OUT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_TREAD: state_next = ST_TMUL;
      ST_TMUL:  state_next = ST_TWB;
      ST_TWB: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_FLCG: state_next = ST_FMUL;
      ST_FMUL: state_next = ST_FWR;
      ST_FWR:  state_next = stat.fill_end ? ST_FLAST : ST_FLCG;
      ST_FLAST: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.wr_sel  = WR_CLEAR;
        cmd.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_IDLE_OUT: begin
        cmd.out_load = stat.out_free;
        cmd.out_zero = 1'b1;
      end
      ST_TREAD: cmd.rd_en = 1'b1;
      ST_TMUL:  cmd.mul_en = 1'b1;
      ST_TWB: begin
        if (stat.out_free) begin
          cmd.tick_commit = 1'b1;
          cmd.wr_sel      = WR_TICK;
          cmd.out_load    = 1'b1;
        end
      end
      ST_FLCG: cmd.lcg_en = 1'b1;
      ST_FMUL: cmd.noise_mul_en = 1'b1;
      ST_FWR: begin
        cmd.wr_sel  = WR_FILL;
        cmd.cnt_inc = 1'b1;
      end
      ST_FLAST: cmd.wr_sel = WR_LAST;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/ksv_dp.sv
// ----------------------------------------------------------------------------
// ksv_dp: datapath of the plucked string voice
// Delay line RAM, phase accumulator, interpolation and decay filter,
// noise generator for the pluck fill, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ksv_dp
  import ksv_pkg::*;
#(
  parameter int DELAY_BITS  = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ksv_cmd_t    cmd,
  output ksv_stat_t        stat,
  input  wire logic [1:0]  func,
  input  wire logic [15:0] gate_level,
  input  wire logic        hard_reset,
  input  wire logic [31:0] phase_step,
  input  wire logic [15:0] decay_plucked,
  input  wire logic [15:0] decay_release,
  input  wire logic [15:0] decay_reset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] sample,
  output logic             active
);

  localparam int DB    = DELAY_BITS;
  localparam int SB    = SAMPLE_BITS;
  localparam int LINE  = 1 << DB;
  localparam int PW    = SB + 18;
  localparam int NW    = SB + 17;
  localparam int YW    = SB + 16;
  localparam int SH_R  = (SB >= 16) ? SB - 16 : 0;
  localparam int SH_L  = (SB < 16) ? 16 - SB : 0;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [PW-1:0] P_MAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};
  localparam logic signed [SB+1:0] T_ONE  = {3'b001, {(SB-1){1'b0}}};
  localparam logic signed [SB+1:0] T_MONE = {3'b111, {(SB-1){1'b0}}};
  localparam logic signed [SB:0]   SUM_MIN = {2'b11, {(SB-1){1'b0}}};
  localparam logic [DB-1:0] FILL_LAST = {{(DB-1){1'b1}}, 1'b0};

  logic [31:0]          phase;
  mode_t                mode;
  logic [31:0]          noise_state;
  logic [DB-1:0]        cnt;
  logic [15:0]          gate_q;
  logic signed [SB:0]   sum;
  logic signed [SB-1:0] y0_q;
  logic signed [PW-1:0] p_interp;
  logic signed [PW-1:0] p_decay;
  logic signed [NW-1:0] noise_prod;

  logic [DB-1:0]        i0;
  logic [DB-1:0]        i1;
  logic [DB-1:0]        i_next;
  logic [15:0]          frac;
  logic [31:0]          phase_next;
  logic [15:0]          gain;
  logic [SB-1:0]        rd_a;
  logic [SB-1:0]        rd_b;
  logic signed [SB-1:0] y0;
  logic signed [SB-1:0] y1;
  logic signed [SB:0]   diff;
  logic signed [SB:0]   pair;

  logic signed [PW-1:0] interp_sh;
  logic signed [PW-1:0] y_full;
  logic signed [SB-1:0] y;
  logic signed [YW-1:0] y_ext;
  logic signed [YW-1:0] s_tmp;
  logic signed [PW-1:0] decay_sh;
  logic signed [SB-1:0] nv;

  logic signed [NW-1:0] v_full;
  logic signed [SB-1:0] v;
  logic signed [SB-1:0] v_flip;
  logic signed [SB-1:0] vs;
  logic signed [SB+1:0] t;
  logic signed [SB:0]   neg_sum;
  logic signed [SB-1:0] last_val;

  logic                 we;
  logic [DB-1:0]        waddr;
  logic [SB-1:0]        wdata;

  ksv_ram #(
    .WIDTH (SB),
    .DEPTH (LINE)
  ) u_line (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (cmd.rd_en),
    .raddr_a (i0),
    .raddr_b (i1),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign i0         = phase[31 -: DB];
  assign i1         = i0 + DB'(1);
  assign frac       = phase[31-DB -: 16];
  assign phase_next = phase + phase_step;
  assign i_next     = phase_next[31 -: DB];
  assign y0         = rd_a;
  assign y1         = rd_b;
  assign diff       = {y1[SB-1], y1} - {y0[SB-1], y0};
  assign pair       = {y1[SB-1], y1} + {y0[SB-1], y0};

  always_comb begin
    case (mode)
      MODE_PLUCKED: gain = decay_plucked;
      MODE_RELEASE: gain = decay_release;
      default:      gain = decay_reset;
    endcase
  end

  always_comb begin
    interp_sh = p_interp >>> 16;
    y_full    = {{(PW-SB){y0_q[SB-1]}}, y0_q} + interp_sh;
    y         = y_full[SB-1:0];
    y_ext     = {{16{y[SB-1]}}, y};
    s_tmp     = (y_ext >>> SH_R) <<< SH_L;
    decay_sh  = p_decay >>> 16;
    if (decay_sh > P_MAX) begin
      nv = S_MAX;
    end else if (decay_sh < P_MIN) begin
      nv = S_MIN;
    end else begin
      nv = decay_sh[SB-1:0];
    end
  end

  always_comb begin
    v_full   = noise_prod >>> 16;
    v        = v_full[SB-1:0];
    v_flip   = (v == S_MIN) ? S_MAX : -v;
    t        = {{2{sum[SB]}}, sum[SB-1:0]} + {{2{v[SB-1]}}, v};
    vs       = ((t > T_ONE) || (t < T_MONE)) ? v_flip : v;
    neg_sum  = -sum;
    last_val = (sum == SUM_MIN) ? S_MAX : neg_sum[SB-1:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = '0;
    case (cmd.wr_sel)
      WR_CLEAR: we = 1'b1;
      WR_FILL: begin
        we    = 1'b1;
        wdata = vs;
      end
      WR_LAST: begin
        we    = 1'b1;
        waddr = '1;
        wdata = last_val;
      end
      WR_TICK: begin
        we    = (i0 != i_next);
        waddr = i0;
        wdata = nv;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      mode        <= MODE_IDLE;
      noise_state <= '0;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
        if (func == FUNC_GATE) begin
          mode <= (gate_level != 16'd0) ? MODE_PLUCKED : MODE_RELEASE;
        end else if (func == FUNC_RESET) begin
          mode <= hard_reset ? MODE_IDLE : MODE_SOFT;
        end
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + DB'(1);
      end
      if (cmd.tick_commit) begin
        phase <= phase_next;
      end
      if (cmd.lcg_en) begin
        noise_state <= 32'(noise_state * LCG_MUL + LCG_ADD);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gate_q <= gate_level;
      sum    <= '0;
    end else if (cmd.wr_sel == WR_FILL) begin
      sum <= sum + {vs[SB-1], vs};
    end
    if (cmd.mul_en) begin
      y0_q     <= y0;
      p_interp <= PW'(diff * $signed({1'b0, frac}));
      p_decay  <= PW'(pair * $signed({1'b0, gain}));
    end
    if (cmd.noise_mul_en) begin
      noise_prod <= NW'($signed(noise_state[31 -: SB]) * $signed({1'b0, gate_q}));
    end
    if (cmd.out_load) begin
      sample <= cmd.out_zero ? 16'sd0 : s_tmp[15:0];
      active <= !cmd.out_zero;
    end
  end

  always_comb begin
    stat.item_tick = (func == FUNC_TICK);
    stat.item_fill = (func == FUNC_GATE) && (gate_level != 16'd0);
    stat.item_hard = (func == FUNC_RESET) && hard_reset;
    stat.mode_idle = (mode == MODE_IDLE);
    stat.fill_end  = (cnt == FILL_LAST);
    stat.clear_end = &cnt;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

FILE: hdl/plucked_string_synth_voice_top.sv
// ----------------------------------------------------------------------------
// plucked_string_synth_voice_top: Karplus-Strong plucked string voice
// Request channel din (func, gate_level, hard_reset), result channel dout
// (sample, active), APB-style register port for pitch and decay gains.
//
// A tick request yields one result; gate and reset requests yield none.
// A sounding tick runs from acceptance to result through these steps: accept,
// RAM read of both neighbor entries, multiply stage, write-back and result
// load. An idle tick goes from acceptance straight to a zero result load.
// The next request is taken once the previous one is done, so a new tick
// is not taken while the registered RAM read and multiply register are busy.
// A pluck fill writes one entry at a time through LCG, scale and write steps,
// over the whole line. A hard reset clears the line; the same clearing pass
// runs after rst, with din.ready low while it runs. Register writes are taken
// at any time.
// The result register holds while dout.ready is low; a tick that finishes
// meanwhile waits in its write-back step until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module plucked_string_synth_voice_top
  import ksv_pkg::*;
#(
  parameter int DELAY_BITS  = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ksv_in_if.sink           din,
  ksv_out_if.source        dout,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [31:0] phase_step;
  logic [15:0] decay_plucked;
  logic [15:0] decay_release;
  logic [15:0] decay_reset;
  logic        cfg_we;
  ksv_cmd_t    cmd;
  ksv_stat_t   stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= PHASE_STEP_RST;
      decay_plucked <= DECAY_PLUCKED_RST;
      decay_release <= DECAY_RELEASE_RST;
      decay_reset   <= DECAY_RESET_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_PHASE_STEP:    phase_step    <= pwdata;
        REG_DECAY_PLUCKED: decay_plucked <= pwdata[15:0];
        REG_DECAY_RELEASE: decay_release <= pwdata[15:0];
        REG_DECAY_RESET:   decay_reset   <= pwdata[15:0];
        default: phase_step <= phase_step;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PHASE_STEP:    prdata = phase_step;
      REG_DECAY_PLUCKED: prdata = {16'd0, decay_plucked};
      REG_DECAY_RELEASE: prdata = {16'd0, decay_release};
      REG_DECAY_RESET:   prdata = {16'd0, decay_reset};
      default:           prdata = '0;
    endcase
  end

  ksv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksv_dp #(
    .DELAY_BITS  (DELAY_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .func          (din.func),
    .gate_level    (din.gate_level),
    .hard_reset    (din.hard_reset),
    .phase_step    (phase_step),
    .decay_plucked (decay_plucked),
    .decay_release (decay_release),
    .decay_reset   (decay_reset),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .sample        (dout.sample),
    .active        (dout.active)
  );

`ifndef SYNTH
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.active) |-> (dout.sample == 16'sd0))
    else $error("idle result carries a nonzero sample");

  a_hard_busy: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.func == FUNC_RESET && din.hard_reset) |=> !din.ready)
    else $error("request taken during clearing pass");

  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.func != FUNC_TICK && !dout.valid) |=> !dout.valid)
    else $error("result produced by a non-tick request");
`endif

endmodule

`default_nettype wire
